[rtl/core/rdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  localparam int RADIX_W  = 5;
  localparam int ALPHA_W  = 64;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int NUM_SYMS = 16;
  localparam int VALUE_W  = 32;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 64;

  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
  localparam logic [ALPHA_W-1:0] ALPHA_LO_RST = 64'h3736353433323130;
  localparam logic [ALPHA_W-1:0] ALPHA_HI_RST = 64'h0000000000003938;

  typedef enum logic [1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [ALPHA_W-1:0] alpha_lo;
    logic [ALPHA_W-1:0] alpha_hi;
  } rdc_cfg_t;

  function automatic logic [CHAR_W-1:0] sym_of(input rdc_cfg_t cfg,
                                                input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] s;
    if (d[DIGIT_W-1]) begin
      s = cfg.alpha_hi[{d[2:0], 3'b000} +: CHAR_W];
    end else begin
      s = cfg.alpha_lo[{d[2:0], 3'b000} +: CHAR_W];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rdc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rdc_front #(
  parameter int VB        = 32,
  parameter int MAX_RADIX = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire  [rdc_pkg::VALUE_W-1:0] in_value,
  input  rdc_pkg::rdc_cfg_t       cfg,
  input  wire                     q_full,
  output logic                    push,
  output logic [VB:0]             push_data
);
  import rdc_pkg::*;

  logic          fr_valid_r, fr_valid_nxt;
  logic [VB-1:0] fr_raw_r;
  logic [VB-1:0] mag;
  logic          neg;
  logic          alpha_ok;
  logic          radix_ok;
  logic [CHAR_W-1:0]   syms [NUM_SYMS];
  logic [NUM_SYMS-1:0] bad;
  logic [NUM_SYMS-1:0] dup_m [NUM_SYMS];

  assign busy = fr_valid_r & q_full;

  always_comb begin
    for (int i = 0; i < NUM_SYMS; i++) begin
      syms[i] = sym_of(cfg, DIGIT_W'(i));
    end
    for (int i = 0; i < NUM_SYMS; i++) begin
      for (int j = 0; j < NUM_SYMS; j++) begin
        dup_m[i][j] = (j < i) && (syms[i] == syms[j]);
      end
      bad[i] = (RADIX_W'(i) < cfg.radix) &&
               ((syms[i] == SYM_PLUS) || (syms[i] == SYM_MINUS) || (|dup_m[i]));
    end
  end

  assign radix_ok = (cfg.radix >= RADIX_W'(2)) && (cfg.radix <= RADIX_W'(MAX_RADIX));
  assign alpha_ok = radix_ok && !(|bad);

  // most negative value maps onto itself, which is its exact magnitude
  assign neg       = fr_raw_r[VB-1];
  assign mag       = neg ? (~fr_raw_r + VB'(1)) : fr_raw_r;
  assign push      = fr_valid_r & ~q_full & alpha_ok;
  assign push_data = {neg, mag};

  always_comb begin
    if (start && !busy) begin
      fr_valid_nxt = 1'b1;
    end else begin
      fr_valid_nxt = fr_valid_r & q_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      fr_raw_r <= in_value[VB-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/rdc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rdc_queue #(
  parameter int W = 33
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire  [W-1:0] push_data,
  output logic         full,
  input  wire          pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  import rdc_pkg::*;

  localparam int DEPTH = 2;

  logic [W-1:0] entry_r [DEPTH];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'(DEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !pop) |=> $stable(cnt_r)) else $error("queue count moved without beat");
`endif

endmodule

`default_nettype wire

[rtl/core/rdc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rdc_back #(
  parameter int VB = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  rdc_pkg::rdc_cfg_t            cfg,
  input  wire                          q_empty,
  output logic                         pop,
  input  wire  [VB:0]                  pop_data,
  output logic                         out_valid,
  output logic [rdc_pkg::CHAR_W-1:0]   out_char_code,
  output logic                         out_last_char
);
  import rdc_pkg::*;

  localparam int CW = $clog2(VB);
  localparam int LW = $clog2(VB + 1);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_CONV  = 4'b0010,
    B_SIGN  = 4'b0100,
    B_DIGIT = 4'b1000
  } back_st_t;

  back_st_t            st_r, st_nxt;
  logic [VB-1:0]       mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [CW-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [DIGIT_W-1:0]  digits_r [VB];
  logic [DIGIT_W-1:0]  digits_nxt [VB];
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [VB-1:0]       gen, prop;
  logic [VB:0]         psum, cin;
  logic                cout [VB];
  logic [RADIX_W-1:0]  twice [VB];
  logic [DIGIT_W-1:0]  dstep [VB];
  logic [LW-1:0]       len_up;

  // one doubling step of the radix-r digit row per magnitude bit
  always_comb begin
    for (int i = 0; i < VB; i++) begin
      twice[i] = {digits_r[i], 1'b0};
      gen[i]   = (twice[i] >= cfg.radix);
      prop[i]  = (twice[i] == (cfg.radix - RADIX_W'(1)));
    end
    psum = {1'b0, gen} + {1'b0, gen | prop} + (VB + 1)'(mag_r[VB-1]);
    cin  = psum ^ {1'b0, gen} ^ {1'b0, gen | prop};
    for (int i = 0; i < VB; i++) begin
      cout[i]  = gen[i] | (prop[i] & cin[i]);
      dstep[i] = cout[i] ? DIGIT_W'({digits_r[i], cin[i]} - cfg.radix)
                         : DIGIT_W'({digits_r[i], cin[i]});
    end
    len_up = len_r + LW'(cin[len_r]);
  end

  assign pop = (st_r == B_IDLE) && !q_empty;

  always_comb begin
    st_nxt        = st_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    digits_nxt    = digits_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          neg_nxt     = pop_data[VB];
          mag_nxt     = pop_data[VB-1:0];
          bit_cnt_nxt = '0;
          len_nxt     = LW'(1);
          for (int i = 0; i < VB; i++) begin
            digits_nxt[i] = '0;
          end
          st_nxt = B_CONV;
        end
      end
      B_CONV: begin
        digits_nxt  = dstep;
        mag_nxt     = {mag_r[VB-2:0], 1'b0};
        len_nxt     = len_up;
        bit_cnt_nxt = bit_cnt_r + CW'(1);
        if (bit_cnt_r == CW'(VB - 1)) begin
          idx_nxt = CW'(len_up - LW'(1));
          st_nxt  = neg_r ? B_SIGN : B_DIGIT;
        end
      end
      B_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = SYM_MINUS;
        out_last_nxt  = 1'b0;
        st_nxt        = B_DIGIT;
      end
      B_DIGIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sym_of(cfg, digits_r[idx_r]);
        out_last_nxt  = (idx_r == '0);
        if (idx_r == '0) begin
          st_nxt = B_IDLE;
        end else begin
          idx_nxt = idx_r - CW'(1);
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    digits_r   <= digits_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

`ifndef NO_ASSERTIONS
  a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(st_r == B_SIGN || st_r == B_DIGIT))
    else $error("result beat outside emit phase");
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("beat right after last character");
  a_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_CONV) |-> (len_r != '0))
    else $error("empty digit row during conversion");
`endif

endmodule

`default_nettype wire

[rtl/core/radix_integer_to_digit_chars.sv]
// channel  | handshake            | payload
// input    | start / busy         | in_value[31:0]
// result   | out_valid (strobe)   | out_char_code[7:0], out_last_char
// config   | psel/penable/pwrite  | paddr[4:3] selects radix, alphabet_low, alphabet_high
//
// The back end is bit-serial: one magnitude bit per cycle through the digit row.
// A two-beat queue lets the front take the next number while the back works.
// Reset is synchronous, active low; no clearing pass.
// Results go out one per cycle on out_valid and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_digit_chars #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [rdc_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  output logic [rdc_pkg::CHAR_W-1:0]   out_char_code,
  output logic                         out_last_char,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [rdc_pkg::ADDR_W-1:0]   paddr,
  input  wire  [rdc_pkg::DATA_W-1:0]   pwdata,
  output logic [rdc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import rdc_pkg::*;

  rdc_cfg_t            cfg_r, cfg_nxt;
  logic                wr_en;
  reg_idx_t            reg_sel;
  logic                q_push, q_pop, q_full, q_empty;
  logic [VALUE_BITS:0] q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_idx_t'(paddr[4:3]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_RADIX:    cfg_nxt.radix    = pwdata[RADIX_W-1:0];
        REG_ALPHA_LO: cfg_nxt.alpha_lo = pwdata;
        REG_ALPHA_HI: cfg_nxt.alpha_hi = pwdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RADIX:    prdata = DATA_W'(cfg_r.radix);
      REG_ALPHA_LO: prdata = cfg_r.alpha_lo;
      REG_ALPHA_HI: prdata = cfg_r.alpha_hi;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radix    <= RADIX_RST;
      cfg_r.alpha_lo <= ALPHA_LO_RST;
      cfg_r.alpha_hi <= ALPHA_HI_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rdc_front #(
    .VB        (VALUE_BITS),
    .MAX_RADIX (MAX_RADIX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_wdata)
  );

  rdc_queue #(
    .W (VALUE_BITS + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rdc_back #(
    .VB (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .pop           (q_pop),
    .pop_data      (q_rdata),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

[tb/radix_integer_to_digit_chars_test.sv]
`timescale 1ns / 1ps

module radix_integer_to_digit_chars_test;
  import rdc_pkg::*;

  localparam int SETTLE_CYCLES  = 300;
  localparam int RANDOM_NUMBERS = 280;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [VALUE_W-1:0]  in_value;
  logic                out_valid;
  logic [CHAR_W-1:0]   out_char_code;
  logic                out_last_char;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [RADIX_W-1:0]  radix_q;
  logic [ALPHA_W-1:0]  alpha_lo_q;
  logic [ALPHA_W-1:0]  alpha_hi_q;

  char_beat_t          expected_chars[$];
  int                  failures;
  int unsigned         burst_left;
  int unsigned         valid_numbers;

  radix_integer_to_digit_chars DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] glyph_of(input int unsigned d);
    logic [2*ALPHA_W-1:0] row;
    row = {alpha_hi_q, alpha_lo_q};
    return row[d*CHAR_W +: CHAR_W];
  endfunction

  function automatic bit alphabet_valid();
    logic [CHAR_W-1:0] s;
    if (radix_q < RADIX_W'(2) || radix_q > RADIX_W'(NUM_SYMS)) return 1'b0;
    for (int i = 0; i < int'(radix_q); i++) begin
      s = glyph_of(i);
      if (s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
      for (int j = 0; j < i; j++) begin
        if (glyph_of(j) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // digits are peeled off least significant first, emitted most significant first
  function automatic void predict_chars(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits [VALUE_W];
    int                 n;
    if (!alphabet_valid()) return;
    mag = value[VALUE_W-1] ? -value : value;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % VALUE_W'(radix_q));
      mag = mag / VALUE_W'(radix_q);
      n++;
    end while (mag != 0 && n < VALUE_W);
    if (value[VALUE_W-1]) expected_chars.push_back('{SYM_MINUS, 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      expected_chars.push_back('{glyph_of(int'(digits[i])), i == 0});
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 40);
      1: v = -$urandom_range(1, 40);
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '1;
          default: v = '0;
        endcase
      end
      3, 4: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin : check_beats
    char_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: char_code %h last_char %b", out_char_code, out_last_char);
        failures++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code: expected %h, actual %h", want.code, out_char_code);
          failures++;
        end
        if (out_last_char !== want.last) begin
          $error("last_char: expected %b, actual %b", want.last, out_last_char);
          failures++;
        end
      end
    end
  end

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(40, 100);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_number(input logic [VALUE_W-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_chars(v);
    pace_sender();
  endtask

  // invalid alphabets give no beats, so allow for numbers still in flight
  task automatic settle();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_RADIX:    radix_q    = data[RADIX_W-1:0];
      REG_ALPHA_LO: alpha_lo_q = data;
      default:      alpha_hi_q = data;
    endcase
    // read back on the same select
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_RADIX) begin
      if (prdata[RADIX_W-1:0] !== data[RADIX_W-1:0]) begin
        $error("%s readback: expected %h, actual %h", idx.name(), data[RADIX_W-1:0],
               prdata[RADIX_W-1:0]);
        failures++;
      end
    end else if (prdata !== data) begin
      $error("%s readback: expected %h, actual %h", idx.name(), data, prdata);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [RADIX_W-1:0] r, input logic [ALPHA_W-1:0] lo,
                            input logic [ALPHA_W-1:0] hi);
    write_register(REG_RADIX, DATA_W'(r));
    write_register(REG_ALPHA_LO, lo);
    write_register(REG_ALPHA_HI, hi);
  endtask

  task automatic test_decimal_after_reset();
    send_number(32'd0);
    send_number(32'd7);
    send_number(-32'sd10);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    settle();
  endtask

  task automatic test_radix_extremes();
    // plus and minus sit in unused entries, which must not matter
    set_config(5'd2, 64'h2D2B_2D2B_2D2B_3130, '1);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    settle();
    set_config(5'd16, ALPHA_LO_RST, 64'h4645_4443_4241_3938);
    send_number(32'hDEAD_BEEF);
    send_number(32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_zero_symbol();
    set_config(5'd3, 64'h0000_0000_007A_FF00, '0);
    send_number(-32'sd100);
    send_number(32'd0);
    settle();
  endtask

  task automatic test_rejected_alphabets();
    logic [RADIX_W-1:0] bad_radix [4];
    bad_radix = '{5'd0, 5'd1, 5'd17, 5'd31};
    foreach (bad_radix[i]) begin
      set_config(bad_radix[i], ALPHA_LO_RST, 64'h4645_4443_4241_3938);
      send_number(32'd123);
      settle();
    end
    set_config(5'd10, 64'h3736_2B34_3332_3130, ALPHA_HI_RST);
    send_number(32'd55);
    settle();
    set_config(5'd10, ALPHA_LO_RST, 64'h0000_0000_0000_2D38);
    send_number(-32'sd9);
    settle();
    set_config(5'd16, ALPHA_LO_RST, 64'h3045_4443_4241_3938);
    send_number(32'hCAFE_F00D);
    settle();
  endtask

  task automatic test_random_alphabets();
    logic [CHAR_W-1:0]  syms [NUM_SYMS];
    logic [ALPHA_W-1:0] lo;
    logic [ALPHA_W-1:0] hi;
    int unsigned        kind;
    int unsigned        r;
    int unsigned        used;
    int unsigned        count;
    int unsigned        p;
    bit                 clash;
    while (valid_numbers < RANDOM_NUMBERS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: r = 2;
        1: r = NUM_SYMS;
        7: r = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(NUM_SYMS + 1, 31);
        default: r = $urandom_range(2, NUM_SYMS);
      endcase
      used = (r > NUM_SYMS) ? NUM_SYMS : r;
      for (int i = 0; i < NUM_SYMS; i++) begin
        syms[i] = CHAR_W'($urandom_range(0, 255));
        if (i < used) begin
          do begin
            clash = (syms[i] == SYM_PLUS) || (syms[i] == SYM_MINUS);
            for (int j = 0; j < i; j++) begin
              if (syms[j] == syms[i]) clash = 1'b1;
            end
            if (clash) syms[i] = CHAR_W'($urandom_range(0, 255));
          end while (clash);
        end
      end
      if (kind == 8) begin
        p = $urandom_range(0, r - 1);
        syms[p] = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
      end else if (kind == 9) begin
        p = $urandom_range(1, r - 1);
        syms[p] = syms[$urandom_range(0, p - 1)];
      end
      for (int i = 0; i < 8; i++) begin
        lo[i*CHAR_W +: CHAR_W] = syms[i];
        hi[i*CHAR_W +: CHAR_W] = syms[i+8];
      end
      set_config(r[RADIX_W-1:0], lo, hi);
      count = (kind >= 7) ? 3 : $urandom_range(20, 40);
      repeat (count) send_number(random_value());
      if (kind < 7) valid_numbers += count;
      settle();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_value      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    radix_q       = RADIX_RST;
    alpha_lo_q    = ALPHA_LO_RST;
    alpha_hi_q    = ALPHA_HI_RST;
    failures      = 0;
    burst_left    = 0;
    valid_numbers = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_decimal_after_reset();
    test_radix_extremes();
    test_zero_symbol();
    test_rejected_alphabets();
    test_random_alphabets();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
